@@ design/smp_pkg.sv @@
package smp_pkg;

  // field widths
  localparam int INDEX_W = 12;
  localparam int COORD_W = 17;
  localparam int COEF_W  = 32;
  localparam int LIMIT_W = 32;

  // configuration port
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int REGSEL_W = 3;

  localparam logic [REGSEL_W-1:0] REG_ROW0  = 3'd0;
  localparam logic [REGSEL_W-1:0] REG_MIXED = 3'd1;
  localparam logic [REGSEL_W-1:0] REG_ROW1  = 3'd2;
  localparam logic [REGSEL_W-1:0] REG_ROW2  = 3'd3;
  localparam logic [REGSEL_W-1:0] REG_LAST  = 3'd4;
  localparam logic [REGSEL_W-1:0] REG_LIMIT = 3'd5;

  localparam logic [COEF_W-1:0]  F_LAST_RESET = 32'd1073741824;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 32'd429496730;

  // datapath widths
  localparam int PROD_W  = 50;   // 32b coefficient times 18b signed coordinate
  localparam int DSUM_W  = 51;   // three-term epipolar sum, Q.46
  localparam int TERM_W  = 35;   // epipolar term after floor to Q.30
  localparam int MAG_W   = 34;   // magnitude of an epipolar term
  localparam int SQ_W    = 68;   // square of a term magnitude
  localparam int DEN_W   = 70;   // sum of four squares
  localparam int RPROD_W = 53;   // coordinate times epipolar term
  localparam int RES_W   = 54;   // residual, Q.46
  localparam int RMAG_W  = 53;
  localparam int RLO_W   = 26;
  localparam int RHI_W   = 27;
  localparam int DLO_W   = 35;
  localparam int DHI_W   = 35;
  localparam int LPROD_W = 67;
  localparam int CMP_W   = 106;

endpackage

@@ design/sampson_inlier_test.sv @@
// Sampson-distance inlier test for one point correspondence.
// Input channel (in_valid/in_ready) carries match_index and the two
// normalized points first_u/v and second_u/v in unsigned Q1.16. Output
// channel (out_valid/out_ready) returns result_index and is_inlier.
// The fundamental matrix (Q1.30) and the Q0.32 threshold sit in an APB
// register file, 64-bit data, register i at byte address 8*i; write it only
// while no word is in flight.
// Throughput: one word per cycle while out_ready stays high. The eight
// register stages, from acceptance to out_valid, are: coefficient products,
// term sums, residual products and term magnitudes, residual sum and squares,
// denominator sum, split squares of the residual and threshold products,
// numerator and limit sums, compare into the output register.
// Each stage holds its word when the next stage is full and stalled, so a
// stalled receiver fills the pipe and then drops in_ready; bubbles are
// squeezed out while out_ready is low.
// Reset (synchronous, active high) empties the pipe and restores the
// register defaults: F all zero but F22 = 1.0, threshold about 0.1.
module sampson_inlier_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smp_pkg::ADDR_W-1:0]         paddr,
  input  logic [smp_pkg::DATA_W-1:0]         pwdata,
  output logic [smp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smp_pkg::INDEX_W-1:0]        match_index,
  input  logic [smp_pkg::COORD_W-1:0]        first_u,
  input  logic [smp_pkg::COORD_W-1:0]        first_v,
  input  logic [smp_pkg::COORD_W-1:0]        second_u,
  input  logic [smp_pkg::COORD_W-1:0]        second_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [smp_pkg::INDEX_W-1:0]        result_index,
  output logic                               is_inlier
);

  // configuration registers
  logic [smp_pkg::DATA_W-1:0]  f_row0_pair;
  logic [smp_pkg::DATA_W-1:0]  f_mixed_pair;
  logic [smp_pkg::DATA_W-1:0]  f_row1_pair;
  logic [smp_pkg::DATA_W-1:0]  f_row2_pair;
  logic [smp_pkg::COEF_W-1:0]  f_last;
  logic [smp_pkg::LIMIT_W-1:0] distance_limit;

  logic                           cfg_write;
  logic [smp_pkg::REGSEL_W-1:0]   cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = paddr[smp_pkg::ADDR_W-1:smp_pkg::ADDR_W-smp_pkg::REGSEL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_row0_pair    <= '0;
      f_mixed_pair   <= '0;
      f_row1_pair    <= '0;
      f_row2_pair    <= '0;
      f_last         <= smp_pkg::F_LAST_RESET;
      distance_limit <= smp_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        smp_pkg::REG_ROW0:  f_row0_pair    <= pwdata;
        smp_pkg::REG_MIXED: f_mixed_pair   <= pwdata;
        smp_pkg::REG_ROW1:  f_row1_pair    <= pwdata;
        smp_pkg::REG_ROW2:  f_row2_pair    <= pwdata;
        smp_pkg::REG_LAST:  f_last         <= pwdata[smp_pkg::COEF_W-1:0];
        smp_pkg::REG_LIMIT: distance_limit <= pwdata[smp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      smp_pkg::REG_ROW0:  prdata = f_row0_pair;
      smp_pkg::REG_MIXED: prdata = f_mixed_pair;
      smp_pkg::REG_ROW1:  prdata = f_row1_pair;
      smp_pkg::REG_ROW2:  prdata = f_row2_pair;
      smp_pkg::REG_LAST:  prdata = {{(smp_pkg::DATA_W-smp_pkg::COEF_W){1'b0}}, f_last};
      smp_pkg::REG_LIMIT: prdata = {{(smp_pkg::DATA_W-smp_pkg::LIMIT_W){1'b0}}, distance_limit};
      default:            prdata = '0;
    endcase
  end

  // matrix entries
  logic signed [smp_pkg::COEF_W-1:0] f00, f01, f02, f10, f11, f12, f20, f21, f22;

  assign f00 = $signed(f_row0_pair[63:32]);
  assign f01 = $signed(f_row0_pair[31:0]);
  assign f02 = $signed(f_mixed_pair[63:32]);
  assign f10 = $signed(f_mixed_pair[31:0]);
  assign f11 = $signed(f_row1_pair[63:32]);
  assign f12 = $signed(f_row1_pair[31:0]);
  assign f20 = $signed(f_row2_pair[63:32]);
  assign f21 = $signed(f_row2_pair[31:0]);
  assign f22 = $signed(f_last);

  // stage enables: a stage loads when it is empty or its successor moves
  logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en, s7_en, out_en;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;

  assign out_en   = !out_valid || out_ready;
  assign s7_en    = !s7_valid || out_en;
  assign s6_en    = !s6_valid || s7_en;
  assign s5_en    = !s5_valid || s6_en;
  assign s4_en    = !s4_valid || s5_en;
  assign s3_en    = !s3_valid || s4_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_valid  <= in_valid;
      if (s2_en)  s2_valid  <= s1_valid;
      if (s3_en)  s3_valid  <= s2_valid;
      if (s4_en)  s4_valid  <= s3_valid;
      if (s5_en)  s5_valid  <= s4_valid;
      if (s6_en)  s6_valid  <= s5_valid;
      if (s7_en)  s7_valid  <= s6_valid;
      if (out_en) out_valid <= s7_valid;
    end
  end

  // stage 1: coefficient times coordinate
  logic signed [smp_pkg::COORD_W:0] u1s, v1s, u2s, v2s;

  assign u1s = $signed({1'b0, first_u});
  assign v1s = $signed({1'b0, first_v});
  assign u2s = $signed({1'b0, second_u});
  assign v2s = $signed({1'b0, second_v});

  logic [smp_pkg::INDEX_W-1:0]        s1_index;
  logic [smp_pkg::COORD_W-1:0]        s1_u2, s1_v2;
  logic signed [smp_pkg::PROD_W-1:0]  s1_au0, s1_au1, s1_av0, s1_av1, s1_aw0, s1_aw1;
  logic signed [smp_pkg::PROD_W-1:0]  s1_bu0, s1_bu1, s1_bv0, s1_bv1;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_index <= match_index;
      s1_u2    <= second_u;
      s1_v2    <= second_v;
      s1_au0   <= f00 * u1s;
      s1_au1   <= f01 * v1s;
      s1_av0   <= f10 * u1s;
      s1_av1   <= f11 * v1s;
      s1_aw0   <= f20 * u1s;
      s1_aw1   <= f21 * v1s;
      s1_bu0   <= f00 * u2s;
      s1_bu1   <= f10 * v2s;
      s1_bv0   <= f01 * u2s;
      s1_bv1   <= f11 * v2s;
    end
  end

  // stage 2: add the constant terms and floor to Q.30
  logic signed [smp_pkg::DSUM_W-1:0] sum_au, sum_av, sum_aw, sum_bu, sum_bv;

  assign sum_au = s1_au0 + s1_au1 + $signed({f02, 16'b0});
  assign sum_av = s1_av0 + s1_av1 + $signed({f12, 16'b0});
  assign sum_aw = s1_aw0 + s1_aw1 + $signed({f22, 16'b0});
  assign sum_bu = s1_bu0 + s1_bu1 + $signed({f20, 16'b0});
  assign sum_bv = s1_bv0 + s1_bv1 + $signed({f21, 16'b0});

  logic [smp_pkg::INDEX_W-1:0]        s2_index;
  logic [smp_pkg::COORD_W-1:0]        s2_u2, s2_v2;
  logic signed [smp_pkg::TERM_W-1:0]  s2_au, s2_av, s2_aw, s2_bu, s2_bv;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_index <= s1_index;
      s2_u2    <= s1_u2;
      s2_v2    <= s1_v2;
      s2_au    <= $signed(sum_au[smp_pkg::DSUM_W-1:16]);
      s2_av    <= $signed(sum_av[smp_pkg::DSUM_W-1:16]);
      s2_aw    <= $signed(sum_aw[smp_pkg::DSUM_W-1:16]);
      s2_bu    <= $signed(sum_bu[smp_pkg::DSUM_W-1:16]);
      s2_bv    <= $signed(sum_bv[smp_pkg::DSUM_W-1:16]);
    end
  end

  // stage 3: residual products and term magnitudes
  logic signed [smp_pkg::COORD_W:0] s2_u2s, s2_v2s;

  assign s2_u2s = $signed({1'b0, s2_u2});
  assign s2_v2s = $signed({1'b0, s2_v2});

  logic [smp_pkg::INDEX_W-1:0]        s3_index;
  logic signed [smp_pkg::RPROD_W-1:0] s3_ru, s3_rv;
  logic signed [smp_pkg::TERM_W-1:0]  s3_aw;
  logic [smp_pkg::MAG_W-1:0]          s3_mau, s3_mav, s3_mbu, s3_mbv;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_index <= s2_index;
      s3_ru    <= s2_u2s * s2_au;
      s3_rv    <= s2_v2s * s2_av;
      s3_aw    <= s2_aw;
      s3_mau   <= s2_au[smp_pkg::TERM_W-1] ? smp_pkg::MAG_W'(-s2_au) : smp_pkg::MAG_W'(s2_au);
      s3_mav   <= s2_av[smp_pkg::TERM_W-1] ? smp_pkg::MAG_W'(-s2_av) : smp_pkg::MAG_W'(s2_av);
      s3_mbu   <= s2_bu[smp_pkg::TERM_W-1] ? smp_pkg::MAG_W'(-s2_bu) : smp_pkg::MAG_W'(s2_bu);
      s3_mbv   <= s2_bv[smp_pkg::TERM_W-1] ? smp_pkg::MAG_W'(-s2_bv) : smp_pkg::MAG_W'(s2_bv);
    end
  end

  // stage 4: residual sum and term squares
  logic signed [smp_pkg::RES_W-1:0] resid;

  assign resid = s3_ru + s3_rv + $signed({s3_aw, 16'b0});

  logic [smp_pkg::INDEX_W-1:0]        s4_index;
  logic signed [smp_pkg::RES_W-1:0]   s4_resid;
  logic [smp_pkg::SQ_W-1:0]           s4_qau, s4_qav, s4_qbu, s4_qbv;

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_index <= s3_index;
      s4_resid <= resid;
      s4_qau   <= s3_mau * s3_mau;
      s4_qav   <= s3_mav * s3_mav;
      s4_qbu   <= s3_mbu * s3_mbu;
      s4_qbv   <= s3_mbv * s3_mbv;
    end
  end

  // stage 5: residual magnitude and denominator
  logic [smp_pkg::INDEX_W-1:0]  s5_index;
  logic [smp_pkg::RMAG_W-1:0]   s5_rmag;
  logic [smp_pkg::DEN_W-1:0]    s5_den;

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_index <= s4_index;
      s5_rmag  <= s4_resid[smp_pkg::RES_W-1] ? smp_pkg::RMAG_W'(-s4_resid)
                                             : smp_pkg::RMAG_W'(s4_resid);
      s5_den   <= smp_pkg::DEN_W'(s4_qau) + smp_pkg::DEN_W'(s4_qav)
                + smp_pkg::DEN_W'(s4_qbu) + smp_pkg::DEN_W'(s4_qbv);
    end
  end

  // stage 6: split products for residual squared and threshold times denominator
  logic [smp_pkg::RHI_W-1:0] rhi;
  logic [smp_pkg::RLO_W-1:0] rlo;
  logic [smp_pkg::DHI_W-1:0] dhi;
  logic [smp_pkg::DLO_W-1:0] dlo;

  assign rhi = s5_rmag[smp_pkg::RMAG_W-1:smp_pkg::RLO_W];
  assign rlo = s5_rmag[smp_pkg::RLO_W-1:0];
  assign dhi = s5_den[smp_pkg::DEN_W-1:smp_pkg::DLO_W];
  assign dlo = s5_den[smp_pkg::DLO_W-1:0];

  logic [smp_pkg::INDEX_W-1:0]              s6_index;
  logic [2*smp_pkg::RHI_W-1:0]              s6_rhh;
  logic [smp_pkg::RHI_W+smp_pkg::RLO_W-1:0] s6_rhl;
  logic [2*smp_pkg::RLO_W-1:0]              s6_rll;
  logic [smp_pkg::LPROD_W-1:0]              s6_lhi, s6_llo;
  logic                                     s6_den_zero;

  always_ff @(posedge clk) begin
    if (s6_en) begin
      s6_index    <= s5_index;
      s6_rhh      <= rhi * rhi;
      s6_rhl      <= rhi * rlo;
      s6_rll      <= rlo * rlo;
      s6_lhi      <= dhi * distance_limit;
      s6_llo      <= dlo * distance_limit;
      s6_den_zero <= (s5_den == '0);
    end
  end

  // stage 7: recombine partial products
  logic [smp_pkg::INDEX_W-1:0] s7_index;
  logic [smp_pkg::CMP_W-1:0]   s7_num, s7_lim;
  logic                        s7_den_zero;

  always_ff @(posedge clk) begin
    if (s7_en) begin
      s7_index    <= s6_index;
      s7_num      <= (smp_pkg::CMP_W'(s6_rhh) << (2 * smp_pkg::RLO_W))
                   + (smp_pkg::CMP_W'(s6_rhl) << (smp_pkg::RLO_W + 1))
                   + smp_pkg::CMP_W'(s6_rll);
      s7_lim      <= (smp_pkg::CMP_W'(s6_lhi) << smp_pkg::DLO_W)
                   + smp_pkg::CMP_W'(s6_llo);
      s7_den_zero <= s6_den_zero;
    end
  end

  // stage 8: compare into the output register; zero denominator never passes
  always_ff @(posedge clk) begin
    if (out_en) begin
      result_index <= s7_index;
      is_inlier    <= !s7_den_zero && (s7_num < s7_lim);
    end
  end

endmodule
